[rtl/cartridge_rtc_register_read_core_macros.svh]
// Assertion macros for the cartridge clock read core.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef CARTRIDGE_RTC_REGISTER_READ_CORE_MACROS_SVH
`define CARTRIDGE_RTC_REGISTER_READ_CORE_MACROS_SVH
`ifndef SYNTH
`define CRTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define CRTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define CRTC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CRTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/crtc_pkg.sv]
// Shared types, codes and helper functions of the cartridge clock read core.
// No dependencies; imported by every module of the block.
`default_nettype none
package crtc_pkg;

    localparam logic [15:0] PORT_ADDR   = 16'hA000;

    localparam logic [3:0]  MODE_TEST   = 4'hA;
    localparam logic [3:0]  MODE_RAM    = 4'hD;
    localparam logic [3:0]  MODE_RTC    = 4'hC;

    localparam logic [3:0]  SEL_DELTA   = 4'd0;
    localparam logic [3:0]  SEL_BCD     = 4'd1;
    localparam logic [3:0]  SEL_DAY_LO  = 4'd7;
    localparam logic [3:0]  SEL_DAY_HI  = 4'd8;
    localparam logic [3:0]  SEL_MONTH   = 4'd9;

    localparam logic [3:0]  BCD_GROUP   = 4'h4;
    localparam logic [3:0]  BCD_MINUTES = 4'h6;
    localparam logic [3:0]  BCD_HOURS   = 4'h7;

    localparam logic [7:0]  TEST_VALUE  = 8'h01;

    localparam logic [5:0]  SEC_MAX     = 6'd59;
    localparam logic [5:0]  MIN_MAX     = 6'd59;
    localparam logic [5:0]  HOUR_MAX    = 6'd23;
    localparam logic [5:0]  DAY_MAX     = 6'd31;
    localparam logic [3:0]  MONTH_MAX   = 4'd12;

    // Reciprocals for the constant divisions by 60 and by 3600 of a 16-bit count.
    localparam logic [15:0] RECIP_60    = 16'd34953;
    localparam int          SHIFT_60    = 21;
    localparam logic [16:0] RECIP_3600  = 17'd74566;
    localparam int          SHIFT_3600  = 28;

    typedef struct packed {
        logic        action;
        logic        addr_hit;
        logic [3:0]  mode;
        logic [3:0]  sel_main;
        logic [3:0]  sel_high;
        logic [3:0]  sel_low;
        logic [5:0]  sec_add;
        logic [5:0]  min_add;
        logic [4:0]  hr_add;
    } t_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        handled;
        logic        ram_request;
        logic [7:0]  ram_offset;
    } t_result;

    function automatic logic [3:0] bcd_tens(input logic [5:0] v);
        logic [10:0] p;
        p = 11'(v) * 11'd26;
        return {1'b0, p[10:8]};
    endfunction

    function automatic logic [3:0] bcd_units(input logic [5:0] v);
        logic [5:0] t;
        t = 6'(bcd_tens(v)) * 6'd10;
        return 4'(v - t);
    endfunction

endpackage
`default_nettype wire

[rtl/crtc_split.sv]
// Input register of the clock read core: captures an item and splits the elapsed count.
// Depends on crtc_pkg for the item type, the port address and the reciprocal constants.
`default_nettype none
module crtc_split
    import crtc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire logic        i_action,
    input  wire logic [15:0] i_elapsed,
    input  wire logic [15:0] i_address,
    input  wire logic [3:0]  i_mode,
    input  wire logic [3:0]  i_sel_main,
    input  wire logic [3:0]  i_sel_high,
    input  wire logic [3:0]  i_sel_low,
    input  wire logic        i_advance,
    output      logic        o_valid,
    output      t_item       o_item
);

    logic        r_valid;
    t_item       r_item;
    t_item       n_item;
    logic [31:0] w_p60;
    logic [32:0] w_p3600;
    logic [10:0] w_q60;
    logic [4:0]  w_q3600;
    logic [15:0] w_q60x;
    logic [10:0] w_q3600x;

    assign w_p60    = 32'(i_elapsed) * 32'(RECIP_60);
    assign w_p3600  = 33'(i_elapsed) * 33'(RECIP_3600);
    assign w_q60    = w_p60[SHIFT_60 +: 11];
    assign w_q3600  = w_p3600[SHIFT_3600 +: 5];
    assign w_q60x   = 16'(w_q60) * 16'd60;
    assign w_q3600x = 11'(w_q3600) * 11'd60;

    always_comb begin
        n_item.action   = i_action;
        n_item.addr_hit = (i_address == PORT_ADDR);
        n_item.mode     = i_mode;
        n_item.sel_main = i_sel_main;
        n_item.sel_high = i_sel_high;
        n_item.sel_low  = i_sel_low;
        n_item.sec_add  = 6'(i_elapsed - w_q60x);
        n_item.min_add  = 6'(w_q60 - w_q3600x);
        n_item.hr_add   = w_q3600;
    end

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

[rtl/crtc_clock.sv]
// Calendar clock registers and the read decoder of the clock read core.
// Depends on crtc_pkg for the item and result types, codes and BCD helpers.
`default_nettype none
module crtc_clock
    import crtc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_item   i_item,
    input  wire logic    i_fire,
    output      t_result o_result
);

    logic [5:0] r_seconds, n_seconds;
    logic [5:0] r_minutes, n_minutes;
    logic [4:0] r_hours,   n_hours;
    logic [5:0] r_day,     n_day;
    logic [3:0] r_month,   n_month;
    logic [5:0] r_last,    n_last;

    logic [6:0] w_sec_sum;
    logic       w_sec_carry;
    logic [6:0] w_min_sum;
    logic       w_min_carry;
    logic [5:0] w_hr_sum;
    logic       w_hr_carry;
    logic [5:0] w_day_sum;
    logic [3:0] w_month_inc;
    logic [5:0] w_bcd_src;
    logic       w_bcd_hit;
    logic       w_delta_read;

    always_comb begin
        w_sec_sum   = 7'(r_seconds) + 7'(i_item.sec_add);
        w_sec_carry = (w_sec_sum > 7'(SEC_MAX));
        w_min_sum   = 7'(r_minutes) + 7'(i_item.min_add) + 7'(w_sec_carry);
        w_min_carry = (w_min_sum > 7'(MIN_MAX));
        w_hr_sum    = 6'(r_hours) + 6'(i_item.hr_add) + 6'(w_min_carry);
        w_hr_carry  = (w_hr_sum > HOUR_MAX);
        w_day_sum   = r_day + 6'(w_hr_carry);
        w_month_inc = r_month + 4'd1;
    end

    always_comb begin
        w_bcd_hit = 1'b1;
        w_bcd_src = 6'd0;
        if (i_item.sel_high == BCD_GROUP && i_item.sel_low == BCD_MINUTES) begin
            w_bcd_src = r_minutes;
        end else if (i_item.sel_high == BCD_GROUP && i_item.sel_low == BCD_HOURS) begin
            w_bcd_src = 6'(r_hours);
        end else begin
            w_bcd_hit = 1'b0;
        end
    end

    always_comb begin
        o_result     = '0;
        w_delta_read = 1'b0;
        if (i_item.addr_hit) begin
            unique case (i_item.mode)
                MODE_TEST: begin
                    o_result.handled   = 1'b1;
                    o_result.read_data = TEST_VALUE;
                end
                MODE_RAM: begin
                    o_result.handled = 1'b1;
                    if (i_item.sel_main == SEL_BCD) begin
                        o_result.read_data = w_bcd_hit ? 8'(bcd_tens(w_bcd_src)) : 8'd0;
                    end else begin
                        o_result.ram_request = 1'b1;
                        o_result.ram_offset  = {i_item.sel_high, i_item.sel_low};
                    end
                end
                MODE_RTC: begin
                    o_result.handled = 1'b1;
                    unique case (i_item.sel_main)
                        SEL_DELTA: begin
                            w_delta_read       = 1'b1;
                            o_result.read_data = (r_seconds == 6'd0) ? 8'd0 :
                                8'(r_seconds) - 8'(r_last) - 8'd1;
                        end
                        SEL_BCD: begin
                            o_result.read_data =
                                w_bcd_hit ? 8'(bcd_units(w_bcd_src)) : 8'd0;
                        end
                        SEL_DAY_LO: o_result.read_data = 8'(r_day[3:0]);
                        SEL_DAY_HI: o_result.read_data = 8'(r_day[5:4]);
                        SEL_MONTH:  o_result.read_data = 8'(r_month);
                        default:    o_result.read_data = 8'd0;
                    endcase
                end
                default: o_result = '0;
            endcase
        end
    end

    always_comb begin
        n_seconds = r_seconds;
        n_minutes = r_minutes;
        n_hours   = r_hours;
        n_day     = r_day;
        n_month   = r_month;
        n_last    = r_last;
        if (i_fire && !i_item.action) begin
            n_seconds = w_sec_carry ? 6'(w_sec_sum - 7'd60) : 6'(w_sec_sum);
            n_minutes = w_min_carry ? 6'(w_min_sum - 7'd60) : 6'(w_min_sum);
            n_hours   = w_hr_carry  ? 5'(w_hr_sum - 6'd24)  : 5'(w_hr_sum);
            if (w_day_sum > DAY_MAX) begin
                n_day   = w_day_sum - DAY_MAX;
                n_month = (w_month_inc > MONTH_MAX) ? w_month_inc - MONTH_MAX : w_month_inc;
            end else begin
                n_day   = w_day_sum;
            end
        end else if (i_fire && w_delta_read) begin
            n_last = r_seconds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seconds <= 6'd0;
            r_minutes <= 6'd0;
            r_hours   <= 5'd0;
            r_day     <= 6'd0;
            r_month   <= 4'd1;
            r_last    <= 6'd0;
        end else begin
            r_seconds <= n_seconds;
            r_minutes <= n_minutes;
            r_hours   <= n_hours;
            r_day     <= n_day;
            r_month   <= n_month;
            r_last    <= n_last;
        end
    end

endmodule
`default_nettype wire

[rtl/cartridge_rtc_register_read_core.sv]
// Cartridge clock read port: input register, clock keeper and output register.
// Slave items carry time advances or bus reads; a read yields one item on the master side.
// Throughput is one item per cycle unless a stalled receiver holds back a read result;
// a read result passes through the input register and then the output register.
// A time item (tuser 0) adds its elapsed seconds to the clock and yields no item.
// A read item (tuser 1) yields exactly one result item, in acceptance order.
// The clock update and the read decode are combinational logic between the two registers,
// which allows the rate of one item per cycle.
// While the receiver stalls, the result holds in the output register and time items
// still pass through; the next read item waits in the input register and blocks the rest.
// Reset clears both valid flags and sets the clock to day 0, month 1, 00:00:00.
// Accepting any item needs no warm-up after reset.
`default_nettype none
`include "cartridge_rtc_register_read_core_macros.svh"
module cartridge_rtc_register_read_core
    import crtc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    // elapsed_seconds[15:0], address[31:16], mode_flag[35:32], sel_main[39:36],
    // sel_high[43:40], sel_low[47:44]
    input  wire logic [47:0] i_s_axis_tdata,
    // action[0]
    input  wire logic        i_s_axis_tuser,
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // read_data[7:0], ram_offset[15:8]
    output      logic [15:0] o_m_axis_tdata,
    // handled[0], ram_request[1]
    output      logic [1:0]  o_m_axis_tuser
);

    logic    w_stage_valid;
    t_item   w_item;
    logic    w_fire;
    logic    w_load;
    t_result w_result;
    logic    r_out_valid;
    t_result r_out;

    crtc_split u_split (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_action   (i_s_axis_tuser),
        .i_elapsed  (i_s_axis_tdata[15:0]),
        .i_address  (i_s_axis_tdata[31:16]),
        .i_mode     (i_s_axis_tdata[35:32]),
        .i_sel_main (i_s_axis_tdata[39:36]),
        .i_sel_high (i_s_axis_tdata[43:40]),
        .i_sel_low  (i_s_axis_tdata[47:44]),
        .i_advance  (w_fire),
        .o_valid    (w_stage_valid),
        .o_item     (w_item)
    );

    crtc_clock u_clock (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_item),
        .i_fire   (w_fire),
        .o_result (w_result)
    );

    assign w_fire = w_stage_valid && (!w_item.action || !r_out_valid || i_m_axis_tready);
    assign w_load = w_fire && w_item.action;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.ram_offset, r_out.read_data};
    assign o_m_axis_tuser  = {r_out.ram_request, r_out.handled};

    `CRTC_ASSERT_IMP(a_ram_needs_handled, i_clk, i_rst_n, r_out_valid && r_out.ram_request, r_out.handled)
    `CRTC_ASSERT_IMP(a_offset_idle_zero, i_clk, i_rst_n, r_out_valid && !r_out.ram_request, r_out.ram_offset == 8'd0)
    `CRTC_ASSERT_NEXT(a_time_no_result, i_clk, i_rst_n, w_fire && !w_item.action && !(r_out_valid && !i_m_axis_tready), !r_out_valid)

endmodule
`default_nettype wire

[tb/sv/crtc_tb_pkg.sv]
`timescale 1ns / 1ps
// Item kinds shared by the clock read port testbench and its checker.
// No dependencies; compiled before the other testbench files.
package crtc_tb_pkg;

    typedef enum logic {
        ACT_TIME = 1'b0,
        ACT_READ = 1'b1
    } t_action;

endpackage

[tb/sv/crtc_read_checker.sv]
`timescale 1ns / 1ps
// Checker for the cartridge clock read core: keeps its own copy of the clock,
// predicts every read answer and compares it with the master-side item.
// Depends on crtc_pkg from the RTL and on crtc_tb_pkg.
module crtc_read_checker
    import crtc_pkg::*;
    import crtc_tb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    // elapsed_seconds[15:0], address[31:16], mode_flag[35:32], sel_main[39:36],
    // sel_high[43:40], sel_low[47:44]
    input  wire logic [47:0] i_s_tdata,
    // action[0]
    input  wire logic        i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    // read_data[7:0], ram_offset[15:8]
    input  wire logic [15:0] i_m_tdata,
    // handled[0], ram_request[1]
    input  wire logic [1:0]  i_m_tuser,
    output int               o_waiting,
    output int               o_errors
);

    logic [5:0] clk_sec;
    logic [5:0] clk_min;
    logic [4:0] clk_hr;
    logic [5:0] clk_day;
    logic [3:0] clk_month;
    logic [5:0] last_sec;
    t_result    expected_reads[$];
    t_result    got;
    t_result    want;

    initial begin
        o_errors  = 0;
        o_waiting = 0;
    end

    task automatic flag_mismatch(input string what);
        o_errors++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    task automatic advance_clock(input logic [15:0] elapsed);
        int rest;
        int s;
        int m;
        int h;
        int d;
        int mo;
        rest = int'(elapsed);
        s  = int'(clk_sec) + rest % 60;
        m  = int'(clk_min);
        h  = int'(clk_hr);
        d  = int'(clk_day);
        mo = int'(clk_month);
        if (s > int'(SEC_MAX)) begin
            s -= 60;
            m++;
        end
        rest /= 60;
        m += rest % 60;
        if (m > int'(MIN_MAX)) begin
            m -= 60;
            h++;
        end
        rest /= 60;
        h += rest % 24;
        if (h > int'(HOUR_MAX)) begin
            h -= 24;
            d++;
        end
        d += rest / 24;
        if (d > int'(DAY_MAX)) begin
            d -= 31;
            mo++;
            if (mo > int'(MONTH_MAX)) begin
                mo -= 12;
            end
        end
        clk_sec   = 6'(s);
        clk_min   = 6'(m);
        clk_hr    = 5'(h);
        clk_day   = 6'(d);
        clk_month = 4'(mo);
    endtask

    function automatic logic [7:0] bcd_digit(input logic [3:0] sh, input logic [3:0] sl,
                                             input bit tens);
        int v;
        if (sh != BCD_GROUP) begin
            return 8'h00;
        end
        if (sl == BCD_MINUTES) begin
            v = int'(clk_min);
        end else if (sl == BCD_HOURS) begin
            v = int'(clk_hr);
        end else begin
            return 8'h00;
        end
        return tens ? 8'((v / 10) % 10) : 8'(v % 10);
    endfunction

    // Reading the seconds-passed delta also moves the last seen second.
    function automatic t_result predict_read(input logic [47:0] item);
        t_result     r;
        logic [15:0] addr;
        logic [3:0]  mode;
        logic [3:0]  sm;
        logic [3:0]  sh;
        logic [3:0]  sl;
        addr = item[31:16];
        mode = item[35:32];
        sm   = item[39:36];
        sh   = item[43:40];
        sl   = item[47:44];
        r    = '0;
        if (addr == PORT_ADDR) begin
            if (mode == MODE_TEST) begin
                r.handled   = 1'b1;
                r.read_data = TEST_VALUE;
            end else if (mode == MODE_RAM) begin
                r.handled = 1'b1;
                if (sm == SEL_BCD) begin
                    r.read_data = bcd_digit(sh, sl, 1'b1);
                end else begin
                    r.ram_request = 1'b1;
                    r.ram_offset  = {sh, sl};
                end
            end else if (mode == MODE_RTC) begin
                r.handled = 1'b1;
                case (sm)
                    SEL_DELTA: begin
                        r.read_data = (clk_sec == 6'd0) ? 8'h00
                                    : 8'(int'(clk_sec) - int'(last_sec) - 1);
                        last_sec = clk_sec;
                    end
                    SEL_BCD:    r.read_data = bcd_digit(sh, sl, 1'b0);
                    SEL_DAY_LO: r.read_data = {4'h0, clk_day[3:0]};
                    SEL_DAY_HI: r.read_data = {6'h00, clk_day[5:4]};
                    SEL_MONTH:  r.read_data = {4'h0, clk_month};
                    default:    r.read_data = 8'h00;
                endcase
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clk_sec   = '0;
            clk_min   = '0;
            clk_hr    = '0;
            clk_day   = '0;
            clk_month = 4'd1;
            last_sec  = '0;
            expected_reads.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.read_data   = i_m_tdata[7:0];
                got.ram_offset  = i_m_tdata[15:8];
                got.handled     = i_m_tuser[0];
                got.ram_request = i_m_tuser[1];
                if (expected_reads.size() == 0) begin
                    flag_mismatch($sformatf("result item %h/%b with no read pending",
                                            i_m_tdata, i_m_tuser));
                end else begin
                    want = expected_reads.pop_front();
                    if (got.read_data !== want.read_data) begin
                        flag_mismatch($sformatf("read_data got %h, expected %h",
                                                got.read_data, want.read_data));
                    end
                    if (got.handled !== want.handled) begin
                        flag_mismatch($sformatf("handled got %b, expected %b",
                                                got.handled, want.handled));
                    end
                    if (got.ram_request !== want.ram_request) begin
                        flag_mismatch($sformatf("ram_request got %b, expected %b",
                                                got.ram_request, want.ram_request));
                    end
                    if (got.ram_offset !== want.ram_offset) begin
                        flag_mismatch($sformatf("ram_offset got %h, expected %h",
                                                got.ram_offset, want.ram_offset));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (t_action'(i_s_tuser) == ACT_READ) begin
                    expected_reads.push_back(predict_read(i_s_tdata));
                end else begin
                    advance_clock(i_s_tdata[15:0]);
                end
            end
        end
        o_waiting <= expected_reads.size();
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Top of the cartridge clock read core testbench: clock, reset, directed and
// random items with random idling on both sides, watchdog and verdict.
// Depends on crtc_pkg, crtc_tb_pkg, crtc_read_checker and the core itself.
module tb;
    import crtc_pkg::*;
    import crtc_tb_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 950;
    localparam int CALM_FROM    = 850;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [47:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    int          waiting;
    int          errors;
    int          idle_odds  = 4;
    bit          calm       = 1'b0;
    int          stall_left = 0;
    int          quiet      = 0;

    always #5 i_clk = ~i_clk;

    cartridge_rtc_register_read_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    crtc_read_checker u_read_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .o_waiting  (waiting),
        .o_errors   (errors)
    );

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        while (quiet < QUIET_LIMIT) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    task automatic push_item(input t_action act, input logic [15:0] elapsed,
                             input logic [15:0] addr, input logic [3:0] mode,
                             input logic [3:0] sm, input logic [3:0] sh,
                             input logic [3:0] sl);
        int gap;
        if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {sl, sh, sm, mode, addr, elapsed};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic push_time(input logic [15:0] elapsed);
        push_item(ACT_TIME, elapsed, 16'($urandom), 4'($urandom), 4'($urandom),
                  4'($urandom), 4'($urandom));
    endtask

    task automatic push_read(input logic [15:0] addr, input logic [3:0] mode,
                             input logic [3:0] sm, input logic [3:0] sh,
                             input logic [3:0] sl);
        push_item(ACT_READ, 16'($urandom), addr, mode, sm, sh, sl);
    endtask

    initial begin
        int          n;
        int          r;
        logic [15:0] addr;
        logic [15:0] elapsed;
        logic [3:0]  mode;
        logic [3:0]  sm;
        logic [3:0]  sh;
        logic [3:0]  sl;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reads of the clock right after reset, every mode and the unhandled cases.
        push_read(PORT_ADDR, MODE_TEST, 4'h0, 4'h0, 4'h0);
        push_read(PORT_ADDR, MODE_RTC, SEL_DAY_LO, 4'h0, 4'h0);
        push_read(PORT_ADDR, MODE_RTC, SEL_DAY_HI, 4'h0, 4'h0);
        push_read(PORT_ADDR, MODE_RTC, SEL_MONTH, 4'h0, 4'h0);
        push_read(PORT_ADDR, MODE_RTC, SEL_DELTA, 4'h0, 4'h0);
        push_read(PORT_ADDR, MODE_RAM, SEL_DELTA, 4'hF, 4'hF);
        push_read(PORT_ADDR, MODE_RAM, 4'h2, 4'h0, 4'h0);
        push_read(PORT_ADDR, MODE_RAM, SEL_BCD, BCD_GROUP, BCD_MINUTES);
        push_read(PORT_ADDR, 4'h0, SEL_DELTA, 4'h0, 4'h0);
        push_read(16'hFFFF, MODE_RTC, SEL_MONTH, 4'h0, 4'h0);
        push_read(16'h0000, MODE_TEST, 4'h0, 4'h0, 4'h0);
        // Seconds carry into minutes, the delta with zero seconds and its wrap.
        push_time(16'd59);
        push_read(PORT_ADDR, MODE_RTC, SEL_DELTA, 4'h0, 4'h0);
        push_time(16'd1);
        push_read(PORT_ADDR, MODE_RTC, SEL_DELTA, 4'h0, 4'h0);
        push_time(16'hFFFF);
        push_read(PORT_ADDR, MODE_RTC, SEL_DELTA, 4'h0, 4'h0);
        push_read(PORT_ADDR, MODE_RTC, SEL_DELTA, 4'h0, 4'h0);
        push_read(PORT_ADDR, MODE_RTC, SEL_BCD, BCD_GROUP, BCD_MINUTES);
        push_read(PORT_ADDR, MODE_RTC, SEL_BCD, BCD_GROUP, BCD_HOURS);
        push_read(PORT_ADDR, MODE_RAM, SEL_BCD, BCD_GROUP, BCD_HOURS);
        push_read(PORT_ADDR, MODE_RTC, SEL_BCD, BCD_GROUP, 4'h5);
        push_read(PORT_ADDR, MODE_RTC, 4'h2, 4'h0, 4'h0);
        push_time(16'd0);
        push_read(PORT_ADDR, MODE_RTC, 4'hF, 4'hF, 4'hF);

        // Mostly long time steps so that days and months roll over several times.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 3))
                    0:       idle_odds <= 0;
                    1:       idle_odds <= 3;
                    2:       idle_odds <= 8;
                    default: idle_odds <= 20;
                endcase
            end
            if (n == CALM_FROM) begin
                calm <= 1'b1;
            end
            if ($urandom_range(0, 99) < 65) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    elapsed = 16'hFFFF - 16'($urandom_range(0, 600));
                end else if (r < 90) begin
                    elapsed = 16'($urandom_range(0, 130));
                end else begin
                    elapsed = 16'($urandom);
                end
                push_time(elapsed);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 88) begin
                    addr = PORT_ADDR;
                end else if (r < 94) begin
                    addr = PORT_ADDR ^ (16'd1 << $urandom_range(0, 15));
                end else begin
                    addr = 16'($urandom);
                end
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    mode = MODE_RTC;
                end else if (r < 62) begin
                    mode = MODE_RAM;
                end else if (r < 77) begin
                    mode = MODE_TEST;
                end else begin
                    mode = 4'($urandom);
                end
                case ($urandom_range(0, 9))
                    0, 1:    sm = SEL_DELTA;
                    2, 3:    sm = SEL_BCD;
                    4:       sm = SEL_DAY_LO;
                    5:       sm = SEL_DAY_HI;
                    6:       sm = SEL_MONTH;
                    default: sm = 4'($urandom);
                endcase
                sh = ($urandom_range(0, 9) < 6) ? BCD_GROUP : 4'($urandom);
                case ($urandom_range(0, 9))
                    0, 1, 2: sl = BCD_MINUTES;
                    3, 4, 5: sl = BCD_HOURS;
                    default: sl = 4'($urandom);
                endcase
                push_read(addr, mode, sm, sh, sl);
            end
        end

        s_tvalid <= 1'b0;
        while (waiting != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
